[rtl/barometer_raw_compensation_macros.svh]
// ---------------------------------------------------------------------------
// Barometer compensation assertion macros
// Concurrent assertion shorthands, clocked on clk_i, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef BAROMETER_RAW_COMPENSATION_MACROS_SVH
`define BAROMETER_RAW_COMPENSATION_MACROS_SVH

// property that holds in the same cycle
`define BRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define BRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bcmp_pkg.sv]
// ---------------------------------------------------------------------------
// bcmp_pkg
// Shared widths and register indexes of the barometer compensation block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcmp_pkg;

  // pipelined divider geometry
  localparam int DivW  = 32;
  localparam int SideW = 45;

  // configuration register indexes
  typedef enum logic [3:0] {
    CfgCoefA1   = 4'd0,
    CfgCoefA2   = 4'd1,
    CfgCoefA3   = 4'd2,
    CfgCoefA4   = 4'd3,
    CfgTempScl  = 4'd4,
    CfgTempCrv  = 4'd5,
    CfgSecOrd   = 4'd6,
    CfgOvrSmp   = 4'd7
  } cfg_idx_e;

  // sideband carried through the temperature divider
  typedef struct packed {
    logic signed [18:0] x1;
    logic               neg;
    logic               dz;
    logic [23:0]        up;
  } tdiv_side_t;

  // sideband carried through the pressure divider
  typedef struct packed {
    logic [29:0]        pad;
    logic signed [11:0] t;
    logic               err;
    logic               big;
    logic               dz;
  } pdiv_side_t;

endpackage

[rtl/bcmp_div.sv]
// ---------------------------------------------------------------------------
// bcmp_div
// Pipelined restoring divider, unsigned, one quotient bit per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcmp_div import bcmp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DivW-1:0]  num_i,
  input  logic [DivW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [DivW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);

  logic             v_q [DivW];
  logic [DivW-1:0]  r_q [DivW];
  logic [DivW-1:0]  n_q [DivW];
  logic [DivW-1:0]  q_q [DivW];
  logic [DivW-1:0]  d_q [DivW];
  logic [SideW-1:0] s_q [DivW];

  logic [DivW-1:0]  r_d [DivW];
  logic [DivW-1:0]  n_d [DivW];
  logic [DivW-1:0]  q_d [DivW];

  // one restoring step per stage
  always_comb begin
    logic [DivW-1:0] r_in;
    logic [DivW-1:0] n_in;
    logic [DivW-1:0] q_in;
    logic [DivW-1:0] d_in;
    logic [DivW:0]   r_sh;
    logic            ge;
    for (int i = 0; i < DivW; i++) begin
      if (i == 0) begin
        r_in = '0;
        n_in = num_i;
        q_in = '0;
        d_in = den_i;
      end else begin
        r_in = r_q[i-1];
        n_in = n_q[i-1];
        q_in = q_q[i-1];
        d_in = d_q[i-1];
      end
      r_sh   = {r_in, n_in[DivW-1]};
      ge     = (r_sh >= {1'b0, d_in});
      r_d[i] = ge ? DivW'(r_sh - {1'b0, d_in}) : r_sh[DivW-1:0];
      n_d[i] = {n_in[DivW-2:0], 1'b0};
      q_d[i] = {q_in[DivW-2:0], ge};
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivW; i++) v_q[i] <= 1'b0;
    end else if (en_i) begin
      for (int i = 0; i < DivW; i++) v_q[i] <= (i == 0) ? valid_i : v_q[i-1];
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < DivW; i++) begin
        r_q[i] <= r_d[i];
        n_q[i] <= n_d[i];
        q_q[i] <= q_d[i];
        d_q[i] <= (i == 0) ? den_i  : d_q[i-1];
        s_q[i] <= (i == 0) ? side_i : s_q[i-1];
      end
    end
  end

  assign valid_o = v_q[DivW-1];
  assign quo_o   = q_q[DivW-1];
  assign side_o  = s_q[DivW-1];

endmodule

[rtl/barometer_raw_compensation.sv]
// ---------------------------------------------------------------------------
// barometer_raw_compensation
// Integer compensation of raw temperature and pressure readings.
// ---------------------------------------------------------------------------
//  channel  | handshake                 | beat contents
//  ---------+---------------------------+----------------------------------
//  in       | in_valid_i / in_stall_o   | raw_temp_i, raw_press_i
//  out      | out_valid_o / out_stall_i | temp_tenths_o, pressure_pa_o,
//           |                           | div_error_o
//  cfg      | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
//  One beat per cycle is accepted unless stalled; results pass through the
//  two 32-stage pipelined dividers plus the multiply stages around them.
//  Reset clears valid bits and restores the calibration defaults.
//  The whole pipeline advances together; a stalled output beat freezes
//  every stage and raises in_stall_o in the same cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "barometer_raw_compensation_macros.svh"

module barometer_raw_compensation import bcmp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        raw_temp_i,
  input  logic [23:0]        raw_press_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [11:0] temp_tenths_o,
  output logic [17:0]        pressure_pa_o,
  output logic               div_error_o
);

  // configuration registers
  logic [15:0] coef_a1_q, coef_a2_q, coef_a3_q, coef_a4_q;
  logic [31:0] tso_q, tcp_q, sop_q;
  logic [1:0]  oss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a1_q <= 16'h0198;
      coef_a2_q <= 16'hFFB8;
      coef_a3_q <= 16'hC7D1;
      coef_a4_q <= 16'h7FE5;
      tso_q     <= 32'h7FF55A71;
      tcp_q     <= 32'hDDF90B34;
      sop_q     <= 32'h182E0004;
      oss_q     <= 2'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgCoefA1:  coef_a1_q <= cfg_wdata_i[15:0];
        CfgCoefA2:  coef_a2_q <= cfg_wdata_i[15:0];
        CfgCoefA3:  coef_a3_q <= cfg_wdata_i[15:0];
        CfgCoefA4:  coef_a4_q <= cfg_wdata_i[15:0];
        CfgTempScl: tso_q     <= cfg_wdata_i;
        CfgTempCrv: tcp_q     <= cfg_wdata_i;
        CfgSecOrd:  sop_q     <= cfg_wdata_i;
        CfgOvrSmp:  oss_q     <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] ac1, ac2, ac3, mc, md, b1, b2;
  logic [15:0]        ac4, ac5, ac6;
  assign ac1 = $signed(coef_a1_q);
  assign ac2 = $signed(coef_a2_q);
  assign ac3 = $signed(coef_a3_q);
  assign ac4 = coef_a4_q;
  assign ac5 = tso_q[31:16];
  assign ac6 = tso_q[15:0];
  assign mc  = $signed(tcp_q[31:16]);
  assign md  = $signed(tcp_q[15:0]);
  assign b1  = $signed(sop_q[31:16]);
  assign b2  = $signed(sop_q[15:0]);

  // global advance
  logic en;
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // ---------------- stage A: temperature product, raw pressure shift
  logic               va_q;
  logic signed [33:0] a_prod_q;
  logic [23:0]        a_up_q;
  logic signed [16:0] a_diff;
  logic signed [33:0] a_prod_d;
  assign a_diff   = $signed({1'b0, raw_temp_i}) - $signed({1'b0, ac6});
  assign a_prod_d = a_diff * $signed({1'b0, ac5});

  // ---------------- stage B: X1 and the temperature divisor
  logic               vb_q;
  logic signed [18:0] b_x1_q;
  logic signed [19:0] b_den_q;
  logic [23:0]        b_up_q;
  logic signed [18:0] b_x1_d;
  assign b_x1_d = a_prod_q[33:15];

  // temperature divider operands
  logic [19:0]     t_den_mag;
  logic [15:0]     t_mc_mag;
  logic [DivW-1:0] t_num, t_den;
  tdiv_side_t      t_side_in, t_side_out;
  logic            t_vo;
  logic [DivW-1:0] t_quo;
  assign t_den_mag      = b_den_q[19] ? 20'(-b_den_q) : b_den_q;
  assign t_mc_mag       = mc[15] ? 16'(-mc) : mc;
  assign t_num          = {5'b0, t_mc_mag, 11'b0};
  assign t_den          = {12'b0, t_den_mag};
  assign t_side_in.x1   = b_x1_q;
  assign t_side_in.neg  = mc[15] ^ b_den_q[19];
  assign t_side_in.dz   = (b_den_q == '0);
  assign t_side_in.up   = b_up_q;

  logic [SideW-1:0] t_side_raw;
  bcmp_div u_tdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vb_q),
    .num_i   (t_num),
    .den_i   (t_den),
    .side_i  (t_side_in),
    .valid_o (t_vo),
    .quo_o   (t_quo),
    .side_o  (t_side_raw)
  );
  assign t_side_out = tdiv_side_t'(t_side_raw);

  // ---------------- stage D: B5
  logic               vd_q;
  logic signed [28:0] d_b5_q;
  logic               d_err_q;
  logic [23:0]        d_up_q;
  logic signed [27:0] d_x2;
  logic signed [28:0] d_b5_d;
  always_comb begin
    if (t_side_out.dz) d_x2 = '0;
    else if (t_side_out.neg) d_x2 = 28'(-$signed(t_quo[27:0]));
    else d_x2 = $signed(t_quo[27:0]);
  end
  assign d_b5_d = $signed({{10{t_side_out.x1[18]}}, t_side_out.x1})
                + $signed({d_x2[27], d_x2});

  // ---------------- stage E: temperature output, B6
  logic               ve_q;
  logic signed [11:0] e_t_q;
  logic signed [28:0] e_b6_q;
  logic [26:0]        e_mag_q;
  logic               e_err_q;
  logic [23:0]        e_up_q;
  logic signed [28:0] e_tsum, e_b6_d;
  logic signed [24:0] e_tsh;
  logic signed [11:0] e_t_d;
  assign e_tsum = d_b5_q + 29'sd8;
  assign e_tsh  = e_tsum[28:4];
  always_comb begin
    if (e_tsh < -25'sd2048) e_t_d = -12'sd2048;
    else if (e_tsh > 25'sd2047) e_t_d = 12'sd2047;
    else e_t_d = e_tsh[11:0];
  end
  assign e_b6_d = d_b5_q - 29'sd4000;

  // ---------------- stage F: square partials, linear products
  logic               vf_q;
  logic [25:0]        f_hh_q;
  logic [26:0]        f_hl_q;
  logic [27:0]        f_ll_q;
  logic signed [44:0] f_ac3b6_q, f_ac2b6_q;
  logic signed [11:0] f_t_q;
  logic               f_err_q;
  logic [23:0]        f_up_q;
  logic [12:0]        f_h;
  logic [13:0]        f_l;
  assign f_h = e_mag_q[26:14];
  assign f_l = e_mag_q[13:0];

  // ---------------- stage G: B6 squared, shifted
  logic               vg_q;
  logic [41:0]        g_b6sq_q;
  logic signed [44:0] g_ac3b6_q, g_ac2b6_q;
  logic signed [11:0] g_t_q;
  logic               g_err_q;
  logic [23:0]        g_up_q;
  logic [53:0]        g_sq;
  assign g_sq = {f_hh_q, 28'b0} + {12'b0, f_hl_q, 15'b0} + {26'b0, f_ll_q};

  // ---------------- stage H: b1, b2 partial products
  logic               vh_q;
  logic signed [37:0] h_b2hi_q, h_b2lo_q, h_b1hi_q, h_b1lo_q;
  logic signed [44:0] h_ac3b6_q, h_ac2b6_q;
  logic signed [11:0] h_t_q;
  logic               h_err_q;
  logic [23:0]        h_up_q;
  logic signed [21:0] h_hi, h_lo;
  assign h_hi = $signed({1'b0, g_b6sq_q[41:21]});
  assign h_lo = $signed({1'b0, g_b6sq_q[20:0]});

  // ---------------- stage I: recombine partials
  logic               vi_q;
  logic signed [58:0] i_pb2_q, i_pb1_q;
  logic signed [44:0] i_ac3b6_q, i_ac2b6_q;
  logic signed [11:0] i_t_q;
  logic               i_err_q;
  logic [23:0]        i_up_q;
  logic signed [58:0] i_pb2_d, i_pb1_d;
  assign i_pb2_d = ($signed({{21{h_b2hi_q[37]}}, h_b2hi_q}) <<< 21)
                 + $signed({{21{h_b2lo_q[37]}}, h_b2lo_q});
  assign i_pb1_d = ($signed({{21{h_b1hi_q[37]}}, h_b1hi_q}) <<< 21)
                 + $signed({{21{h_b1lo_q[37]}}, h_b1lo_q});

  // ---------------- stage J: X3 for B3 and for B4
  logic               vj_q;
  logic signed [48:0] j_x3t_q;
  logic [31:0]        j_x3p_q;
  logic signed [11:0] j_t_q;
  logic               j_err_q;
  logic [23:0]        j_up_q;
  logic signed [47:0] j_x1t;
  logic signed [33:0] j_x2t;
  logic signed [31:0] j_x1p;
  logic signed [42:0] j_x2p;
  logic signed [44:0] j_psum;
  logic signed [48:0] j_x3t_d;
  assign j_x1t   = i_pb2_q[58:11];
  assign j_x2t   = i_ac2b6_q[44:11];
  assign j_x1p   = i_ac3b6_q[44:13];
  assign j_x2p   = i_pb1_q[58:16];
  assign j_x3t_d = $signed({j_x1t[47], j_x1t}) + $signed({{15{j_x2t[33]}}, j_x2t});
  assign j_psum  = $signed({{13{j_x1p[31]}}, j_x1p}) + $signed({{2{j_x2p[42]}}, j_x2p})
                 + 45'sd2;

  // ---------------- stage K: B3 numerator, B4
  logic               vk_q;
  logic signed [49:0] k_s_q;
  logic [16:0]        k_b4_q;
  logic signed [11:0] k_t_q;
  logic               k_err_q;
  logic [23:0]        k_up_q;
  logic signed [49:0] k_s_d;
  logic [31:0]        k_m4;
  assign k_s_d = $signed({{32{ac1[15]}}, ac1, 2'b0}) + $signed({j_x3t_q[48], j_x3t_q});
  assign k_m4  = {16'b0, ac4} * (j_x3p_q + 32'd32768);

  // ---------------- stage L: B3 with truncating divide by four
  logic               vl_q;
  logic [31:0]        l_b3_q;
  logic [16:0]        l_b4_q;
  logic signed [11:0] l_t_q;
  logic               l_err_q;
  logic [23:0]        l_up_q;
  logic signed [52:0] l_val, l_adj;
  assign l_val = ($signed({{3{k_s_q[49]}}, k_s_q}) <<< oss_q) + 53'sd2;
  assign l_adj = l_val + (l_val[52] ? 53'sd3 : 53'sd0);

  // ---------------- stage M: B7
  logic               vm_q;
  logic [31:0]        m_b7_q;
  logic [16:0]        m_b4_q;
  logic signed [11:0] m_t_q;
  logic               m_err_q;
  logic [15:0]        m_k;
  logic [31:0]        m_b7_d;
  assign m_k    = 16'd50000 >> oss_q;
  assign m_b7_d = ({8'b0, l_up_q} - l_b3_q) * {16'b0, m_k};

  // pressure divider operands
  pdiv_side_t       p_side_in, p_side_out;
  logic [DivW-1:0]  p_num, p_den, p_quo;
  logic             p_vo;
  logic [SideW-1:0] p_side_raw;
  assign p_num          = m_b7_q[31] ? m_b7_q : {m_b7_q[30:0], 1'b0};
  assign p_den          = {15'b0, m_b4_q};
  assign p_side_in.pad  = '0;
  assign p_side_in.t    = m_t_q;
  assign p_side_in.err  = m_err_q;
  assign p_side_in.big  = m_b7_q[31];
  assign p_side_in.dz   = (m_b4_q == '0);

  bcmp_div u_pdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vm_q),
    .num_i   (p_num),
    .den_i   (p_den),
    .side_i  (p_side_in),
    .valid_o (p_vo),
    .quo_o   (p_quo),
    .side_o  (p_side_raw)
  );
  assign p_side_out = pdiv_side_t'(p_side_raw);

  // ---------------- stage O: first pressure estimate
  logic               vo_q;
  logic [32:0]        o_p_q;
  logic signed [11:0] o_t_q;
  logic               o_err_q, o_dz_q;

  // ---------------- stage P: square of p/256, linear term
  logic               vp_q;
  logic [49:0]        p_sq_q;
  logic [45:0]        p_m2_q;
  logic [32:0]        p_p_q;
  logic signed [11:0] p_t_q;
  logic               p_err_q, p_dz_q;
  logic [24:0]        p_ps;
  logic [49:0]        p_sq_d;
  logic [45:0]        p_m2_d;
  assign p_ps   = o_p_q[32:8];
  assign p_sq_d = {25'b0, p_ps} * {25'b0, p_ps};
  assign p_m2_d = {13'b0, o_p_q} * 46'd7357;

  // ---------------- stage Q: times 3038 in two halves
  logic               vq_q;
  logic [36:0]        q_hi_q, q_lo_q;
  logic [45:0]        q_m2_q;
  logic [32:0]        q_p_q;
  logic signed [11:0] q_t_q;
  logic               q_err_q, q_dz_q;
  logic [36:0]        q_hi_d, q_lo_d;
  assign q_hi_d = {12'b0, p_sq_q[49:25]} * 37'd3038;
  assign q_lo_d = {12'b0, p_sq_q[24:0]} * 37'd3038;

  // ---------------- stage R: shifted second-order terms
  logic               vr_q;
  logic [45:0]        r_x1_q;
  logic signed [31:0] r_x2_q;
  logic [32:0]        r_p_q;
  logic signed [11:0] r_t_q;
  logic               r_err_q, r_dz_q;
  logic [61:0]        r_full;
  logic [46:0]        r_ceil;
  assign r_full = {q_hi_q, 25'b0} + {25'b0, q_lo_q};
  assign r_ceil = {1'b0, q_m2_q} + 47'd65535;

  // ---------------- stage S: final pressure, output register
  logic signed [47:0] s_sum;
  logic signed [43:0] s_corr;
  logic signed [48:0] s_p2;
  logic [17:0]        s_press;
  assign s_sum  = $signed({2'b0, r_x1_q}) + $signed({{16{r_x2_q[31]}}, r_x2_q})
                + 48'sd3791;
  assign s_corr = s_sum[47:4];
  assign s_p2   = $signed({16'b0, r_p_q}) + $signed({{5{s_corr[43]}}, s_corr});
  always_comb begin
    if (r_dz_q) s_press = '0;
    else if (s_p2 < 49'sd0) s_press = '0;
    else if (s_p2 > 49'sd262143) s_press = 18'h3FFFF;
    else s_press = s_p2[17:0];
  end

  logic signed [11:0] out_t_q;
  logic [17:0]        out_p_q;
  logic               out_e_q;

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0; vb_q <= 1'b0; vd_q <= 1'b0; ve_q <= 1'b0;
      vf_q <= 1'b0; vg_q <= 1'b0; vh_q <= 1'b0; vi_q <= 1'b0;
      vj_q <= 1'b0; vk_q <= 1'b0; vl_q <= 1'b0; vm_q <= 1'b0;
      vo_q <= 1'b0; vp_q <= 1'b0; vq_q <= 1'b0; vr_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i; vb_q <= va_q; vd_q <= t_vo; ve_q <= vd_q;
      vf_q <= ve_q; vg_q <= vf_q; vh_q <= vg_q; vi_q <= vh_q;
      vj_q <= vi_q; vk_q <= vj_q; vl_q <= vk_q; vm_q <= vl_q;
      vo_q <= p_vo; vp_q <= vo_q; vq_q <= vp_q; vr_q <= vq_q;
      out_valid_q <= vr_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      // A
      a_prod_q <= a_prod_d;
      a_up_q   <= 24'(raw_press_i >> (4'd8 - {2'b0, oss_q}));
      // B
      b_x1_q   <= b_x1_d;
      b_den_q  <= $signed({b_x1_d[18], b_x1_d}) + $signed({{4{md[15]}}, md});
      b_up_q   <= a_up_q;
      // D
      d_b5_q   <= d_b5_d;
      d_err_q  <= t_side_out.dz;
      d_up_q   <= t_side_out.up;
      // E
      e_t_q    <= e_t_d;
      e_b6_q   <= e_b6_d;
      e_mag_q  <= e_b6_d[28] ? 27'(-e_b6_d) : e_b6_d[26:0];
      e_err_q  <= d_err_q;
      e_up_q   <= d_up_q;
      // F
      f_hh_q    <= {13'b0, f_h} * {13'b0, f_h};
      f_hl_q    <= {14'b0, f_h} * {13'b0, f_l};
      f_ll_q    <= {14'b0, f_l} * {14'b0, f_l};
      f_ac3b6_q <= $signed({{29{ac3[15]}}, ac3}) * $signed({{16{e_b6_q[28]}}, e_b6_q});
      f_ac2b6_q <= $signed({{29{ac2[15]}}, ac2}) * $signed({{16{e_b6_q[28]}}, e_b6_q});
      f_t_q     <= e_t_q;
      f_err_q   <= e_err_q;
      f_up_q    <= e_up_q;
      // G
      g_b6sq_q  <= g_sq[53:12];
      g_ac3b6_q <= f_ac3b6_q;
      g_ac2b6_q <= f_ac2b6_q;
      g_t_q     <= f_t_q;
      g_err_q   <= f_err_q;
      g_up_q    <= f_up_q;
      // H
      h_b2hi_q  <= $signed({{22{b2[15]}}, b2}) * $signed({{16{h_hi[21]}}, h_hi});
      h_b2lo_q  <= $signed({{22{b2[15]}}, b2}) * $signed({{16{h_lo[21]}}, h_lo});
      h_b1hi_q  <= $signed({{22{b1[15]}}, b1}) * $signed({{16{h_hi[21]}}, h_hi});
      h_b1lo_q  <= $signed({{22{b1[15]}}, b1}) * $signed({{16{h_lo[21]}}, h_lo});
      h_ac3b6_q <= g_ac3b6_q;
      h_ac2b6_q <= g_ac2b6_q;
      h_t_q     <= g_t_q;
      h_err_q   <= g_err_q;
      h_up_q    <= g_up_q;
      // I
      i_pb2_q   <= i_pb2_d;
      i_pb1_q   <= i_pb1_d;
      i_ac3b6_q <= h_ac3b6_q;
      i_ac2b6_q <= h_ac2b6_q;
      i_t_q     <= h_t_q;
      i_err_q   <= h_err_q;
      i_up_q    <= h_up_q;
      // J
      j_x3t_q <= j_x3t_d;
      j_x3p_q <= j_psum[33:2];
      j_t_q   <= i_t_q;
      j_err_q <= i_err_q;
      j_up_q  <= i_up_q;
      // K
      k_s_q   <= k_s_d;
      k_b4_q  <= k_m4[31:15];
      k_t_q   <= j_t_q;
      k_err_q <= j_err_q;
      k_up_q  <= j_up_q;
      // L
      l_b3_q  <= l_adj[33:2];
      l_b4_q  <= k_b4_q;
      l_t_q   <= k_t_q;
      l_err_q <= k_err_q;
      l_up_q  <= k_up_q;
      // M
      m_b7_q  <= m_b7_d;
      m_b4_q  <= l_b4_q;
      m_t_q   <= l_t_q;
      m_err_q <= l_err_q;
      // O
      o_p_q   <= p_side_out.big ? {p_quo, 1'b0} : {1'b0, p_quo};
      o_t_q   <= p_side_out.t;
      o_err_q <= p_side_out.err | p_side_out.dz;
      o_dz_q  <= p_side_out.dz;
      // P
      p_sq_q  <= p_sq_d;
      p_m2_q  <= p_m2_d;
      p_p_q   <= o_p_q;
      p_t_q   <= o_t_q;
      p_err_q <= o_err_q;
      p_dz_q  <= o_dz_q;
      // Q
      q_hi_q  <= q_hi_d;
      q_lo_q  <= q_lo_d;
      q_m2_q  <= p_m2_q;
      q_p_q   <= p_p_q;
      q_t_q   <= p_t_q;
      q_err_q <= p_err_q;
      q_dz_q  <= p_dz_q;
      // R
      r_x1_q  <= r_full[61:16];
      r_x2_q  <= -$signed({1'b0, r_ceil[46:16]});
      r_p_q   <= q_p_q;
      r_t_q   <= q_t_q;
      r_err_q <= q_err_q;
      r_dz_q  <= q_dz_q;
      // output
      out_t_q <= r_t_q;
      out_p_q <= s_press;
      out_e_q <= r_err_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign temp_tenths_o = out_t_q;
  assign pressure_pa_o = out_p_q;
  assign div_error_o   = out_e_q;

  // a held pipeline keeps both divider outputs frozen
  `BRC_ASSERT_NEXT(a_tdiv_hold, !en, $stable(t_vo) && $stable(t_quo), "tdiv moved under stall")
  `BRC_ASSERT_NEXT(a_pdiv_hold, !en, $stable(p_vo) && $stable(p_quo), "pdiv moved under stall")
  // a zero B4 divisor always flags an error in the next stage
  `BRC_ASSERT_NEXT(a_dz_flag, en && p_vo && p_side_out.dz, o_err_q && o_dz_q, "B4 zero lost")

endmodule

[bench/tb_barometer_raw_compensation.sv]
// ---------------------------------------------------------------------------
// tb_barometer_raw_compensation
// Self-checking bench for the barometer compensation pipeline. Raw beats are
// driven through a directed table and then in random form under several
// calibration settings. An in-bench model of the integer algorithm predicts
// every result beat, and the output beats are checked in order against it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_barometer_raw_compensation;
  import bcmp_pkg::*;

  localparam logic [3:0] CfgUnused = 4'd15;  // no register behind this index
  localparam int         Drain     = 120;    // cycles past the last result

  typedef struct packed {
    logic signed [11:0] temp;
    logic [17:0]        press;
    logic               err;
  } comp_res_t;

  typedef struct {
    logic [15:0] ut;
    logic [23:0] rp;
    bit          typed;  // pressure divisor zero: pressure 0, error set
  } raw_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [3:0]         cfg_idx_i = '0;
  logic [31:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [15:0]        raw_temp_i = '0;
  logic [23:0]        raw_press_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [11:0] temp_tenths_o;
  logic [17:0]        pressure_pa_o;
  logic               div_error_o;

  // calibration shadow
  logic [15:0] sh_a1, sh_a2, sh_a3, sh_a4;
  logic [31:0] sh_scl, sh_crv, sh_sec;
  logic [1:0]  sh_oss;

  comp_res_t pending_q[$];
  int        n_bad = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        hold_req = 0;

  always #10 clk_i = ~clk_i;

  barometer_raw_compensation u_dut (.*);

  // integer compensation, 64-bit signed intermediates
  function automatic comp_res_t compensate(logic [15:0] ut_in, logic [23:0] rp_in);
    longint    ac1, ac2, ac3, ac4, ac5, ac6, mc, md, b1, b2, ut;
    longint    x1, x2, x3, b5, b6, b6sq, b3, t, p;
    bit [31:0] up, x3w, b4, b7, q;
    bit [63:0] prod;
    comp_res_t r;
    ac1 = longint'($signed(sh_a1));
    ac2 = longint'($signed(sh_a2));
    ac3 = longint'($signed(sh_a3));
    ac4 = longint'(sh_a4);
    ac5 = longint'(sh_scl[31:16]);
    ac6 = longint'(sh_scl[15:0]);
    mc  = longint'($signed(sh_crv[31:16]));
    md  = longint'($signed(sh_crv[15:0]));
    b1  = longint'($signed(sh_sec[31:16]));
    b2  = longint'($signed(sh_sec[15:0]));
    ut  = longint'(ut_in);
    up  = 32'(rp_in) >> (8 - sh_oss);
    r.err = 1'b0;
    x1 = ((ut - ac6) * ac5) >>> 15;
    if (x1 + md == 0) begin
      r.err = 1'b1;
      x2 = 0;
    end else begin
      x2 = (mc * 2048) / (x1 + md);
    end
    b5 = x1 + x2;
    t = (b5 + 8) >>> 4;
    t = t < -2048 ? -2048 : (t > 2047 ? 2047 : t);
    r.temp = t[11:0];
    b6   = b5 - 4000;
    b6sq = (b6 * b6) >>> 12;
    x1 = (b2 * b6sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = ((ac1 * 4 + x3) * (longint'(1) << sh_oss) + 2) / 4;
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * b6sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    x3w  = 32'(x3 + 32768);
    prod = 64'(ac4) * 64'(x3w);
    b4   = prod[31:0] >> 15;
    b7   = (up - b3[31:0]) * (32'd50000 >> sh_oss);
    if (b4 == 0) begin
      r.err = 1'b1;
      p = 0;
    end else begin
      if (b7 < 32'h8000_0000) begin
        q = (b7 * 32'd2) / b4;
        p = longint'(q);
      end else begin
        q = b7 / b4;
        p = longint'(q) * 2;
      end
      x1 = (p >>> 8) * (p >>> 8);
      x1 = (x1 * 3038) >>> 16;
      x2 = (-7357 * p) >>> 16;
      p = p + ((x1 + x2 + 3791) >>> 4);
      p = p < 0 ? 0 : (p > 262143 ? 262143 : p);
    end
    r.press = p[17:0];
    return r;
  endfunction

  // register write, mirrored into the shadow copy
  task automatic cfg_write(logic [3:0] idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CfgCoefA1:  sh_a1  = val[15:0];
      CfgCoefA2:  sh_a2  = val[15:0];
      CfgCoefA3:  sh_a3  = val[15:0];
      CfgCoefA4:  sh_a4  = val[15:0];
      CfgTempScl: sh_scl = val;
      CfgTempCrv: sh_crv = val;
      CfgSecOrd:  sh_sec = val;
      CfgOvrSmp:  sh_oss = val[1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic cfg_set(logic [15:0] a1, a2, a3, a4, logic [31:0] scl, crv, sec,
                         logic [1:0] oss);
    cfg_write(CfgCoefA1, {16'hdead, a1});
    cfg_write(CfgCoefA2, 32'(a2));
    cfg_write(CfgCoefA3, 32'(a3));
    cfg_write(CfgCoefA4, 32'(a4));
    cfg_write(CfgTempScl, scl);
    cfg_write(CfgTempCrv, crv);
    cfg_write(CfgSecOrd, sec);
    cfg_write(CfgOvrSmp, {30'h3fff_ffff, oss});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one input beat; entered and left at a rising edge
  task automatic send_beat(logic [15:0] ut, logic [23:0] rp, bit typed);
    bit        ok;
    comp_res_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    raw_temp_i  <= ut;
    raw_press_i <= rp;
    do begin
      @(negedge clk_i);
      ok = !in_stall_o;
      @(posedge clk_i);
    end while (!ok);
    r = compensate(ut, rp);
    if (typed) begin
      r.press = '0;
      r.err   = 1'b1;
    end
    pending_q.push_back(r);
  endtask

  // wait for every result, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic random_beats(int n);
    logic [15:0] ut;
    logic [23:0] rp;
    repeat (n) begin
      if ($urandom_range(3) != 0) begin
        ut = 16'($urandom_range(34000, 22000));
        rp = 24'($urandom_range(120000, 60000)) << (8 - sh_oss);
      end else begin
        ut = 16'($urandom);
        rp = 24'($urandom);
      end
      send_beat(ut, rp, 1'b0);
    end
  endtask

  // output side: stall pattern and in-order check
  initial begin
    comp_res_t exp_r;
    static int hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
      @(negedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result beat at %0t", $realtime);
        end else begin
          exp_r = pending_q.pop_front();
          if (exp_r.temp !== temp_tenths_o || exp_r.press !== pressure_pa_o ||
              exp_r.err !== div_error_o) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch: temp %0d/%0d press %0d/%0d err %0b/%0b (exp/got)",
                       exp_r.temp, temp_tenths_o, exp_r.press, pressure_pa_o,
                       exp_r.err, div_error_o);
          end
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("tb_barometer_raw_compensation: errors");
    $finish;
  end

  // stimulus
  initial begin
    static raw_row_t dir_tab[12] = '{
      '{16'd27898, 24'd23843 << 6, 1'b0},  // datasheet-like sample
      '{16'h0000,  24'h000000,     1'b0},
      '{16'hffff,  24'hffffff,     1'b0},
      '{16'h0000,  24'hffffff,     1'b0},
      '{16'hffff,  24'h000000,     1'b0},
      '{16'h5555,  24'haaaaaa,     1'b0},
      '{16'haaaa,  24'h555555,     1'b0},
      '{16'd23153, 24'h400000,     1'b0},  // ut equal to ac6
      '{16'd30000, 24'h800000,     1'b0},
      '{16'd1,     24'h000001,     1'b0},
      '{16'h8000,  24'h7fffff,     1'b0},
      '{16'd25000, 24'd100000 << 6, 1'b0}
    };
    logic [15:0] zt;
    sh_a1 = 16'd408;    sh_a2 = 16'hffb8; sh_a3 = 16'hc7d1; sh_a4 = 16'd32741;
    sh_scl = 32'h7ff55a71; sh_crv = 32'hddf90b34; sh_sec = 32'h182e0004; sh_oss = 2'd2;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows on reset calibration
    foreach (dir_tab[i]) send_beat(dir_tab[i].ut, dir_tab[i].rp, dir_tab[i].typed);
    drain();

    // extremes of every register, plus a write to an unused index
    cfg_write(CfgUnused, 32'hffff_ffff);
    cfg_set(16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 32'hffff_ffff, 32'h7fff_7fff,
            32'h7fff_7fff, 2'd3);
    foreach (dir_tab[i]) send_beat(dir_tab[i].ut, dir_tab[i].rp, 1'b0);
    drain();
    cfg_set(16'h8000, 16'h8000, 16'h8000, 16'h0001, 32'h0000_0000, 32'h8000_8000,
            32'h8000_8000, 2'd0);
    foreach (dir_tab[i]) send_beat(dir_tab[i].ut, dir_tab[i].rp, 1'b0);
    drain();

    // pressure divisor zero: ac4 of zero forces B4 to zero
    cfg_set(16'd408, 16'hffb8, 16'hc7d1, 16'h0000, 32'h7ff55a71, 32'hddf90b34,
            32'h182e0004, 2'd1);
    send_beat(16'd27898, 24'h123456, 1'b1);
    send_beat(16'hffff, 24'hffffff, 1'b1);
    send_beat(16'h0000, 24'h000000, 1'b1);
    drain();

    // temperature divisor zero: ac5 32768, ac6 0 gives X1 = UT, md = -UT
    zt = 16'd100;
    cfg_set(16'd408, 16'hffb8, 16'hc7d1, 16'd32741, 32'h8000_0000,
            {16'hddf9, 16'(-100)}, 32'h182e0004, 2'd2);
    send_beat(zt, 24'h9a0000, 1'b0);
    send_beat(16'd101, 24'h9a0000, 1'b0);
    drain();

    // random phases across idle patterns and calibration sets
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 2) begin
        cfg_set(16'd408, 16'hffb8, 16'hc7d1, 16'd32741, 32'h7ff55a71, 32'hddf90b34,
                32'h182e0004, 2'(ph * 3));
      end else if (ph >= 6) begin
        cfg_set(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                $urandom, $urandom, 2'($urandom));
      end else begin
        cfg_set(16'($urandom_range(600, 200)), 16'(-$urandom_range(200, 0)),
                16'(-$urandom_range(16000, 12000)), 16'($urandom_range(34000, 31000)),
                {16'($urandom_range(33000, 24000)), 16'($urandom_range(26000, 18000))},
                {16'(-$urandom_range(9000, 8000)), 16'($urandom_range(3000, 2500))},
                {16'($urandom_range(6500, 5500)), 16'($urandom_range(60, 0))},
                2'($urandom));
      end
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      if (ph == 4) begin
        // long receiver hold-off while beats keep coming: pipeline backs up
        hold_req = 400;
        random_beats(120);
      end else begin
        random_beats(65);
      end
      idle_pct = 0;
      random_beats(5);
      drain();
    end

    if (n_bad == 0 && pending_q.size() == 0) begin
      $display("tb_barometer_raw_compensation: clean");
    end else begin
      $display("tb_barometer_raw_compensation: errors");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/bcmp_pkg.sv
rtl/bcmp_div.sv
rtl/barometer_raw_compensation.sv
bench/tb_barometer_raw_compensation.sv
